/* rtl/core/hdse_pkg.sv */
// hdse_pkg: shared types, parse script and calendar tables for the http date parser
// used by hdse_front, hdse_queue, hdse_back and the top level
package hdse_pkg;

    typedef enum logic [3:0] {
        OP_WS, OP_NAME, OP_LIT, OP_DIG, OP_MON, OP_PAD, OP_DAY2, OP_END, OP_BAD
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] arg;
        logic [5:0] nxt;
    } script_t;

    // parsed request handed from front to back
    typedef struct packed {
        logic        parse_ok;
        logic [1:0]  fmt;
        logic [6:0]  day;
        logic [3:0]  mon;
        logic [13:0] year;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
    } hdse_job_t;

    localparam logic [7:0] F_DAY  = 8'd0;
    localparam logic [7:0] F_HOUR = 8'd1;
    localparam logic [7:0] F_MIN  = 8'd2;
    localparam logic [7:0] F_SEC  = 8'd3;
    localparam logic [7:0] F_YEAR = 8'd4;

    localparam logic [5:0] PH_WS    = 6'd0;
    localparam logic [5:0] PH_NAME  = 6'd1;
    localparam logic [5:0] PH_IMF   = 6'd2;
    localparam logic [5:0] PH_RFC   = 6'd15;
    localparam logic [5:0] PH_ASC   = 6'd39;
    localparam logic [5:0] PH_COUNT = 6'd62;

    localparam logic [1:0] FMT_NONE = 2'd0;
    localparam logic [1:0] FMT_IMF  = 2'd1;
    localparam logic [1:0] FMT_RFC  = 2'd2;
    localparam logic [1:0] FMT_ASC  = 2'd3;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    localparam logic [6:0] PIVOT_RESET = 7'd69;

    localparam logic [7:0] DAY_CHR [7][9] = '{
        '{"s", "u", "n", "d", "a", "y", 8'h00, 8'h00, 8'h00},
        '{"m", "o", "n", "d", "a", "y", 8'h00, 8'h00, 8'h00},
        '{"t", "u", "e", "s", "d", "a", "y", 8'h00, 8'h00},
        '{"w", "e", "d", "n", "e", "s", "d", "a", "y"},
        '{"t", "h", "u", "r", "s", "d", "a", "y", 8'h00},
        '{"f", "r", "i", "d", "a", "y", 8'h00, 8'h00, 8'h00},
        '{"s", "a", "t", "u", "r", "d", "a", "y", 8'h00}
    };
    localparam logic [3:0] DAY_LEN [7] = '{4'd6, 4'd6, 4'd7, 4'd9, 4'd8, 4'd6, 4'd8};

    localparam logic [7:0] MON_CHR [12][3] = '{
        '{"j", "a", "n"}, '{"f", "e", "b"}, '{"m", "a", "r"}, '{"a", "p", "r"},
        '{"m", "a", "y"}, '{"j", "u", "n"}, '{"j", "u", "l"}, '{"a", "u", "g"},
        '{"s", "e", "p"}, '{"o", "c", "t"}, '{"n", "o", "v"}, '{"d", "e", "c"}
    };
    localparam logic [4:0] MON_DAYS [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };
    // days before the first of the month, counting the year from march
    localparam logic [8:0] MON_CUM [12] = '{
        9'd306, 9'd337, 9'd0, 9'd31, 9'd61, 9'd92,
        9'd122, 9'd153, 9'd184, 9'd214, 9'd245, 9'd275
    };

    localparam logic [24:0] EPOCH_DAYS_OFS = 25'd719469;
    localparam logic signed [17:0] RECIP_25 = 18'sd5243;
    localparam logic signed [17:0] SECS_PER_DAY = 18'sd86400;

    function automatic script_t ent(op_t op, logic [7:0] arg, logic [5:0] nxt);
        script_t r;
        r.op  = op;
        r.arg = arg;
        r.nxt = nxt;
        return r;
    endfunction

    function automatic script_t script_f(logic [5:0] ph);
        script_t r;
        case (ph)
            6'd0:  r = ent(OP_WS, 8'd0, 6'd0);
            6'd1:  r = ent(OP_NAME, 8'd0, 6'd1);
            6'd2:  r = ent(OP_LIT, CH_SP, 6'd3);
            6'd3:  r = ent(OP_DIG, F_DAY, 6'd4);
            6'd4:  r = ent(OP_DIG, F_DAY, 6'd5);
            6'd5:  r = ent(OP_LIT, CH_SP, 6'd6);
            6'd6:  r = ent(OP_MON, 8'd0, 6'd7);
            6'd7:  r = ent(OP_MON, 8'd1, 6'd8);
            6'd8:  r = ent(OP_MON, 8'd2, 6'd9);
            6'd9:  r = ent(OP_LIT, CH_SP, 6'd10);
            6'd10: r = ent(OP_DIG, F_YEAR, 6'd11);
            6'd11: r = ent(OP_DIG, F_YEAR, 6'd12);
            6'd12: r = ent(OP_DIG, F_YEAR, 6'd13);
            6'd13: r = ent(OP_DIG, F_YEAR, 6'd14);
            6'd14: r = ent(OP_LIT, CH_SP, 6'd26);
            6'd15: r = ent(OP_LIT, CH_SP, 6'd16);
            6'd16: r = ent(OP_DIG, F_DAY, 6'd17);
            6'd17: r = ent(OP_DIG, F_DAY, 6'd18);
            6'd18: r = ent(OP_LIT, CH_DASH, 6'd19);
            6'd19: r = ent(OP_MON, 8'd0, 6'd20);
            6'd20: r = ent(OP_MON, 8'd1, 6'd21);
            6'd21: r = ent(OP_MON, 8'd2, 6'd22);
            6'd22: r = ent(OP_LIT, CH_DASH, 6'd23);
            6'd23: r = ent(OP_DIG, F_YEAR, 6'd24);
            6'd24: r = ent(OP_DIG, F_YEAR, 6'd25);
            6'd25: r = ent(OP_LIT, CH_SP, 6'd26);
            6'd26: r = ent(OP_DIG, F_HOUR, 6'd27);
            6'd27: r = ent(OP_DIG, F_HOUR, 6'd28);
            6'd28: r = ent(OP_LIT, CH_COLON, 6'd29);
            6'd29: r = ent(OP_DIG, F_MIN, 6'd30);
            6'd30: r = ent(OP_DIG, F_MIN, 6'd31);
            6'd31: r = ent(OP_LIT, CH_COLON, 6'd32);
            6'd32: r = ent(OP_DIG, F_SEC, 6'd33);
            6'd33: r = ent(OP_DIG, F_SEC, 6'd34);
            6'd34: r = ent(OP_LIT, CH_SP, 6'd35);
            6'd35: r = ent(OP_LIT, "G", 6'd36);
            6'd36: r = ent(OP_LIT, "M", 6'd37);
            6'd37: r = ent(OP_LIT, "T", 6'd38);
            6'd38: r = ent(OP_END, 8'd0, 6'd38);
            6'd39: r = ent(OP_MON, 8'd0, 6'd40);
            6'd40: r = ent(OP_MON, 8'd1, 6'd41);
            6'd41: r = ent(OP_MON, 8'd2, 6'd42);
            6'd42: r = ent(OP_LIT, CH_SP, 6'd43);
            6'd43: r = ent(OP_PAD, 8'd44, 6'd45);
            6'd44: r = ent(OP_PAD, 8'd44, 6'd46);
            6'd45: r = ent(OP_DAY2, 8'd0, 6'd47);
            6'd46: r = ent(OP_DAY2, 8'd48, 6'd47);
            6'd47: r = ent(OP_LIT, CH_SP, 6'd48);
            6'd48: r = ent(OP_DIG, F_HOUR, 6'd49);
            6'd49: r = ent(OP_DIG, F_HOUR, 6'd50);
            6'd50: r = ent(OP_LIT, CH_COLON, 6'd51);
            6'd51: r = ent(OP_DIG, F_MIN, 6'd52);
            6'd52: r = ent(OP_DIG, F_MIN, 6'd53);
            6'd53: r = ent(OP_LIT, CH_COLON, 6'd54);
            6'd54: r = ent(OP_DIG, F_SEC, 6'd55);
            6'd55: r = ent(OP_DIG, F_SEC, 6'd56);
            6'd56: r = ent(OP_LIT, CH_SP, 6'd57);
            6'd57: r = ent(OP_DIG, F_YEAR, 6'd58);
            6'd58: r = ent(OP_DIG, F_YEAR, 6'd59);
            6'd59: r = ent(OP_DIG, F_YEAR, 6'd60);
            6'd60: r = ent(OP_DIG, F_YEAR, 6'd61);
            6'd61: r = ent(OP_END, 8'd0, 6'd61);
            default: r = ent(OP_BAD, 8'd0, 6'd0);
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/hdse_front.sv */
// hdse_front: byte-wise parser of the date string, one byte per cycle
// depends on hdse_pkg; hands one hdse_job_t per string to the queue
module hdse_front import hdse_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        byte_acc,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [6:0]  pivot,
    output logic        job_push,
    output hdse_job_t   job
);

    logic [5:0]  phase_reg, phase_next;
    logic [3:0]  nlen_reg, nlen_next;
    logic [6:0]  cand_reg, cand_next;
    logic [11:0] mmask_reg, mmask_next;
    logic [6:0]  day_reg, day_next;
    logic [3:0]  mon_reg, mon_next;
    logic [13:0] year_reg, year_next;
    logic [6:0]  hour_reg, hour_next;
    logic [6:0]  min_reg, min_next;
    logic [6:0]  sec_reg, sec_next;
    logic [1:0]  fmt_reg, fmt_next;
    logic        fail_reg, fail_next;

    script_t     e;
    logic [7:0]  lc;
    logic        is_dig, is_ws;
    logic [3:0]  dval;
    logic [3:0]  nm_n;
    logic [6:0]  nm_cand;
    logic [6:0]  nm_keep;
    logic        nm_len_hit;
    logic [11:0] mbase, mkeep;
    logic [3:0]  mlow;

    assign e      = script_f(phase_reg);
    assign lc     = (data_byte >= "A" && data_byte <= "Z") ? data_byte + 8'd32 : data_byte;
    assign is_dig = data_byte >= "0" && data_byte <= "9";
    assign is_ws  = data_byte == CH_SP || data_byte == CH_TAB;
    assign dval   = 4'(data_byte - CH_ZERO);

    // day-name match, restarted when the first name letter arrives
    assign nm_n    = (e.op == OP_WS) ? 4'd0 : nlen_reg;
    assign nm_cand = (e.op == OP_WS) ? 7'h7F : cand_reg;

    always_comb begin
        nm_keep    = '0;
        nm_len_hit = 1'b0;
        for (int k = 0; k < 7; k++) begin
            if (nm_cand[k] && DAY_LEN[k] == nm_n) nm_len_hit = 1'b1;
            if (nm_cand[k] && nm_n < DAY_LEN[k] && nm_n < 4'd9) begin
                if (lc == DAY_CHR[k][nm_n]) nm_keep[k] = 1'b1;
            end
        end
    end

    always_comb begin
        mbase = (e.arg[1:0] == 2'd0) ? 12'hFFF : mmask_reg;
        mkeep = '0;
        for (int m = 0; m < 12; m++) begin
            if (mbase[m] && lc == MON_CHR[m][e.arg[1:0]]) mkeep[m] = 1'b1;
        end
        mlow = '0;
        for (int m = 11; m >= 0; m--) begin
            if (mkeep[m]) mlow = 4'(m);
        end
    end

    always_comb begin
        phase_next = phase_reg;
        nlen_next  = nlen_reg;
        cand_next  = cand_reg;
        mmask_next = mmask_reg;
        day_next   = day_reg;
        mon_next   = mon_reg;
        year_next  = year_reg;
        hour_next  = hour_reg;
        min_next   = min_reg;
        sec_next   = sec_reg;
        fmt_next   = fmt_reg;
        fail_next  = fail_reg;
        job_push   = 1'b0;
        job        = '0;

        if (byte_acc) begin
            if (!fail_reg) begin
                if (phase_reg >= PH_COUNT) begin
                    fail_next = 1'b1;
                end else begin
                    case (e.op)
                        OP_WS, OP_NAME: begin
                            if (e.op == OP_WS && is_ws) begin
                                phase_next = phase_reg;
                            end else begin
                                phase_next = (e.op == OP_WS) ? PH_NAME : phase_reg;
                                nlen_next  = nm_n;
                                cand_next  = nm_cand;
                                if (nm_n == 4'd3 && data_byte == CH_COMMA && nm_cand != '0) begin
                                    fmt_next   = FMT_IMF;
                                    phase_next = PH_IMF;
                                end else if (nm_n == 4'd3 && data_byte == CH_SP
                                             && nm_cand != '0) begin
                                    fmt_next   = FMT_ASC;
                                    phase_next = PH_ASC;
                                end else if (data_byte == CH_COMMA && nm_n >= 4'd6
                                             && nm_n <= 4'd9) begin
                                    if (nm_len_hit) begin
                                        fmt_next   = FMT_RFC;
                                        phase_next = PH_RFC;
                                    end else begin
                                        fail_next = 1'b1;
                                    end
                                end else if (nm_n >= 4'd9 || nm_keep == '0) begin
                                    fail_next = 1'b1;
                                end else begin
                                    cand_next = nm_keep;
                                    nlen_next = nm_n + 4'd1;
                                end
                            end
                        end
                        OP_LIT: begin
                            if (data_byte == e.arg) phase_next = e.nxt;
                            else fail_next = 1'b1;
                        end
                        OP_DIG: begin
                            if (is_dig) begin
                                phase_next = e.nxt;
                                case (e.arg)
                                    F_DAY:   day_next  = 7'(day_reg * 7'd10 + 7'(dval));
                                    F_HOUR:  hour_next = 7'(hour_reg * 7'd10 + 7'(dval));
                                    F_MIN:   min_next  = 7'(min_reg * 7'd10 + 7'(dval));
                                    F_SEC:   sec_next  = 7'(sec_reg * 7'd10 + 7'(dval));
                                    default: year_next = 14'(year_reg * 14'd10 + 14'(dval));
                                endcase
                            end else begin
                                fail_next = 1'b1;
                            end
                        end
                        OP_MON: begin
                            mmask_next = mkeep;
                            if (mkeep == '0) begin
                                fail_next = 1'b1;
                            end else begin
                                if (e.arg[1:0] == 2'd2) mon_next = mlow;
                                phase_next = e.nxt;
                            end
                        end
                        OP_PAD: begin
                            if (is_ws) begin
                                phase_next = e.arg[5:0];
                            end else if (is_dig) begin
                                day_next   = 7'(dval);
                                phase_next = e.nxt;
                            end else begin
                                fail_next = 1'b1;
                            end
                        end
                        OP_DAY2: begin
                            if (is_dig) begin
                                day_next   = 7'(day_reg * 7'd10 + 7'(dval));
                                phase_next = e.nxt;
                            end else if (data_byte == CH_SP && e.arg != 8'd0) begin
                                phase_next = e.arg[5:0];
                            end else begin
                                fail_next = 1'b1;
                            end
                        end
                        default: fail_next = 1'b1;
                    endcase
                end
            end

            if (last_byte) begin
                job_push       = 1'b1;
                job.parse_ok   = !fail_next && phase_next < PH_COUNT
                                 && script_f(phase_next).op == OP_END;
                job.fmt        = fmt_next;
                job.day        = day_next;
                job.mon        = mon_next;
                job.hour       = hour_next;
                job.minute     = min_next;
                job.second     = sec_next;
                if (fmt_next == FMT_RFC) begin
                    job.year = (year_next >= 14'(pivot)) ? year_next + 14'd1900
                                                         : year_next + 14'd2000;
                end else begin
                    job.year = year_next;
                end
                phase_next = PH_WS;
                nlen_next  = '0;
                cand_next  = 7'h7F;
                mmask_next = '0;
                day_next   = '0;
                mon_next   = '0;
                year_next  = '0;
                hour_next  = '0;
                min_next   = '0;
                sec_next   = '0;
                fmt_next   = FMT_NONE;
                fail_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_WS;
            nlen_reg  <= '0;
            cand_reg  <= 7'h7F;
            mmask_reg <= '0;
            day_reg   <= '0;
            mon_reg   <= '0;
            year_reg  <= '0;
            hour_reg  <= '0;
            min_reg   <= '0;
            sec_reg   <= '0;
            fmt_reg   <= FMT_NONE;
            fail_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            nlen_reg  <= nlen_next;
            cand_reg  <= cand_next;
            mmask_reg <= mmask_next;
            day_reg   <= day_next;
            mon_reg   <= mon_next;
            year_reg  <= year_next;
            hour_reg  <= hour_next;
            min_reg   <= min_next;
            sec_reg   <= sec_next;
            fmt_reg   <= fmt_next;
            fail_reg  <= fail_next;
        end
    end

endmodule

/* rtl/core/hdse_queue.sv */
// hdse_queue: small request queue between parser front and epoch back
// depends on hdse_pkg for hdse_job_t
module hdse_queue import hdse_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  hdse_job_t din,
    input  logic      pop,
    output hdse_job_t dout,
    output logic      full,
    output logic      empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hdse_job_t         mem [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]     cnt_reg;

    assign full  = cnt_reg == CW'(DEPTH);
    assign empty = cnt_reg == '0;
    assign dout  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= din;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop) cnt_reg <= cnt_reg + CW'(1);
            else if (pop && !push) cnt_reg <= cnt_reg - CW'(1);
        end
    end

endmodule

/* rtl/core/hdse_back.sv */
// hdse_back: date validation and epoch conversion, one shared multiplier
// depends on hdse_pkg; drives the result output register
module hdse_back import hdse_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  hdse_job_t   q_head,
    input  logic        q_empty,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic [2:0]  m_tuser
);

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_DIV1 = 5'b00010,
        B_DIV2 = 5'b00100,
        B_DAYS = 5'b01000,
        B_SECS = 5'b10000
    } bst_t;

    bst_t               st_reg;
    hdse_job_t          job_reg;
    logic [7:0]         q100_reg;
    logic               cen_reg;
    logic signed [24:0] days_reg;
    logic [18:0]        hms_reg;
    logic               ok_reg;
    logic               valid_reg;
    logic [39:0]        tdata_reg;
    logic [2:0]         tuser_reg;

    logic [13:0]        yp;
    logic signed [24:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [42:0] prod;
    logic [7:0]         quot;
    logic               leap;
    logic [5:0]         dmax;
    logic [24:0]        pos, neg;
    logic [38:0]        secs;
    logic               out_free;
    logic               range_ok;

    assign yp   = job_reg.year - ((job_reg.mon < 4'd2) ? 14'd1 : 14'd0);

    // one multiplier: reciprocal divides by 25, then days to seconds
    always_comb begin
        case (st_reg)
            B_DIV1:  begin mul_a = 25'(yp >> 2);           mul_b = RECIP_25;     end
            B_DIV2:  begin mul_a = 25'(job_reg.year >> 2); mul_b = RECIP_25;     end
            B_SECS:  begin mul_a = days_reg;               mul_b = SECS_PER_DAY; end
            default: begin mul_a = '0;                     mul_b = '0;           end
        endcase
    end
    assign prod = mul_a * mul_b;
    assign quot = prod[24:17];

    assign leap = job_reg.year[1:0] == 2'b00 && (!cen_reg || job_reg.year[3:0] == 4'b0000);
    assign dmax = (job_reg.mon < 4'd12)
                  ? 6'(MON_DAYS[job_reg.mon]) + ((job_reg.mon == 4'd1 && leap) ? 6'd1 : 6'd0)
                  : 6'd0;

    // y/400 is (y/100)/4 for non-negative y
    assign pos = 25'(yp) * 25'd365 + 25'(yp >> 2) + 25'(q100_reg >> 2)
               + ((job_reg.mon < 4'd12) ? 25'(MON_CUM[job_reg.mon]) : 25'd0)
               + 25'(job_reg.day);
    assign neg = 25'(q100_reg) + EPOCH_DAYS_OFS;

    assign range_ok = job_reg.parse_ok && job_reg.mon < 4'd12
                      && job_reg.year >= 14'd1 && job_reg.year <= 14'd9999
                      && job_reg.day >= 7'd1 && 6'(job_reg.day) <= dmax
                      && job_reg.day < 7'd64
                      && job_reg.hour <= 7'd23 && job_reg.minute <= 7'd59
                      && job_reg.second <= 7'd60;

    assign secs     = prod[38:0] + 39'(hms_reg);
    assign out_free = !valid_reg || m_tready;
    assign q_pop    = st_reg == B_IDLE && !q_empty;

    assign m_tvalid = valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

    always_ff @(posedge aclk) begin
        case (st_reg)
            B_IDLE: if (!q_empty) job_reg <= q_head;
            B_DIV1: q100_reg <= quot;
            B_DIV2: cen_reg <= (job_reg.year >> 2) == 12'(quot * 12'd25);
            B_DAYS: begin
                days_reg <= $signed(pos - neg);
                hms_reg  <= 19'(job_reg.hour) * 19'd3600 + 19'(job_reg.minute) * 19'd60
                          + 19'(job_reg.second);
                ok_reg   <= range_ok;
            end
            default: ;
        endcase
        if (st_reg == B_SECS && out_free) begin
            tdata_reg <= ok_reg ? {1'b0, secs} : '0;
            tuser_reg <= ok_reg ? {job_reg.fmt, 1'b1} : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= B_IDLE;
            valid_reg <= 1'b0;
        end else begin
            if (m_tready) valid_reg <= 1'b0;
            case (st_reg)
                B_IDLE: if (!q_empty) st_reg <= B_DIV1;
                B_DIV1: st_reg <= B_DIV2;
                B_DIV2: st_reg <= B_DAYS;
                B_DAYS: st_reg <= B_SECS;
                B_SECS: begin
                    if (out_free) begin
                        valid_reg <= 1'b1;
                        st_reg    <= B_IDLE;
                    end
                end
                default: st_reg <= B_IDLE;
            endcase
        end
    end

endmodule

/* rtl/core/http_date_string_to_epoch.sv */
// channel   | dir | tdata                    | tuser / tlast
// s_ (in)   | in  | [7:0] data_byte          | tlast: last_byte
// m_ (out)  | out | [38:0] epoch_seconds     | tuser [0] date_ok, [2:1] date_format
// cfg       | in  | cfg_wdata [6:0] two_digit_year_pivot, written when cfg_wen is high
//
// one byte per cycle through the parser while the request queue has room
// each string's conversion in the back unit runs two reciprocal divides, then the day
// count, then the day-to-second product on one multiplier, then the output handoff
// reset (aresetn low, synchronous) clears parser, queue and output; pivot returns to 69
// a stalled result holds in the output register; parsing goes on until the queue fills
//
// top level: http date string to epoch seconds; depends on hdse_pkg,
// hdse_front, hdse_queue and hdse_back
module http_date_string_to_epoch import hdse_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [38:0] epoch_seconds, [39] zero fill
    output logic [2:0]  m_tuser,   // [0] date_ok, [2:1] date_format
    input  logic        cfg_wen,
    input  logic [6:0]  cfg_wdata
);

    logic [6:0] pivot_reg;
    logic       job_push;
    hdse_job_t  job_in, job_head;
    logic       q_full, q_empty, q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) pivot_reg <= PIVOT_RESET;
        else if (cfg_wen) pivot_reg <= cfg_wdata;
    end

    assign s_tready = !q_full;

    hdse_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_acc  (s_tvalid && s_tready),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .pivot     (pivot_reg),
        .job_push  (job_push),
        .job       (job_in)
    );

    hdse_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (job_push),
        .din     (job_in),
        .pop     (q_pop),
        .dout    (job_head),
        .full    (q_full),
        .empty   (q_empty)
    );

    hdse_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_head   (job_head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* rtl/core/hdse_chk.sv */
// hdse_chk: port-level checks on the result channel of the date parser
// bound to http_date_string_to_epoch; no package needed
module hdse_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // failed parse gives all-zero payload
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 40'd0 && m_tuser[2:1] == 2'd0)
        else $error("failed result carries nonzero fields");

    // good parse names a format and keeps the fill bit clear
    a_ok_fmt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tuser[2:1] != 2'd0 && !m_tdata[39])
        else $error("ok result without a format");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind http_date_string_to_epoch hdse_chk u_hdse_chk (.*);

/* tb/http_date_string_to_epoch_tb.sv */
// testbench for http_date_string_to_epoch: streams date strings byte by byte,
// predicts ok / format / epoch per string and checks every result; depends on hdse_pkg
`timescale 1ns / 1ps

module http_date_string_to_epoch_tb;
    import hdse_pkg::*;

    typedef struct packed {
        logic [7:0] b;
        logic       l;
    } char_t;

    typedef struct packed {
        logic              ok;
        logic [1:0]        fmt;
        logic signed [38:0] secs;
    } epoch_res_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] arg;
        logic [5:0] nx;
    } rule_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_wen = 1'b0;
    logic [6:0]  cfg_wdata = 7'd0;

    http_date_string_to_epoch uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    char_t      feed_q[$];
    epoch_res_t epoch_q[$];
    bit         quiet = 0;
    int         errors = 0;
    int         bytes_sent = 0;
    int         strings_done = 0;
    int         ok_seen = 0;
    int         fmt_seen[4] = '{0, 0, 0, 0};

    string day_names[7] = '{"sunday", "monday", "tuesday", "wednesday", "thursday",
                            "friday", "saturday"};
    string mon_names = "janfebmaraprmayjunjulaugsepoctnovdec";
    int    mon_len[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    // parser mirror
    logic [6:0]  pivot = PIVOT_RESET;
    logic [5:0]  ph;
    logic [3:0]  nlen;
    logic [6:0]  dcand;
    logic [11:0] mcand;
    int          dv, mv, yv, hv, miv, sv;
    logic [1:0]  ffmt;
    bit          fail;

    function automatic rule_t rule(logic [5:0] p);
        rule_t r;
        case (p)
            0: r = '{OP_WS, 0, 0};
            1: r = '{OP_NAME, 0, 1};
            2: r = '{OP_LIT, " ", 3};     3: r = '{OP_DIG, F_DAY, 4};
            4: r = '{OP_DIG, F_DAY, 5};   5: r = '{OP_LIT, " ", 6};
            6: r = '{OP_MON, 0, 7};       7: r = '{OP_MON, 1, 8};
            8: r = '{OP_MON, 2, 9};       9: r = '{OP_LIT, " ", 10};
            10: r = '{OP_DIG, F_YEAR, 11}; 11: r = '{OP_DIG, F_YEAR, 12};
            12: r = '{OP_DIG, F_YEAR, 13}; 13: r = '{OP_DIG, F_YEAR, 14};
            14: r = '{OP_LIT, " ", 26};
            15: r = '{OP_LIT, " ", 16};    16: r = '{OP_DIG, F_DAY, 17};
            17: r = '{OP_DIG, F_DAY, 18};  18: r = '{OP_LIT, "-", 19};
            19: r = '{OP_MON, 0, 20};      20: r = '{OP_MON, 1, 21};
            21: r = '{OP_MON, 2, 22};      22: r = '{OP_LIT, "-", 23};
            23: r = '{OP_DIG, F_YEAR, 24}; 24: r = '{OP_DIG, F_YEAR, 25};
            25: r = '{OP_LIT, " ", 26};
            26: r = '{OP_DIG, F_HOUR, 27}; 27: r = '{OP_DIG, F_HOUR, 28};
            28: r = '{OP_LIT, ":", 29};    29: r = '{OP_DIG, F_MIN, 30};
            30: r = '{OP_DIG, F_MIN, 31};  31: r = '{OP_LIT, ":", 32};
            32: r = '{OP_DIG, F_SEC, 33};  33: r = '{OP_DIG, F_SEC, 34};
            34: r = '{OP_LIT, " ", 35};    35: r = '{OP_LIT, "G", 36};
            36: r = '{OP_LIT, "M", 37};    37: r = '{OP_LIT, "T", 38};
            38: r = '{OP_END, 0, 38};
            39: r = '{OP_MON, 0, 40};      40: r = '{OP_MON, 1, 41};
            41: r = '{OP_MON, 2, 42};      42: r = '{OP_LIT, " ", 43};
            43: r = '{OP_PAD, 44, 45};     44: r = '{OP_PAD, 44, 46};
            45: r = '{OP_DAY2, 0, 47};     46: r = '{OP_DAY2, 48, 47};
            47: r = '{OP_LIT, " ", 48};
            48: r = '{OP_DIG, F_HOUR, 49}; 49: r = '{OP_DIG, F_HOUR, 50};
            50: r = '{OP_LIT, ":", 51};    51: r = '{OP_DIG, F_MIN, 52};
            52: r = '{OP_DIG, F_MIN, 53};  53: r = '{OP_LIT, ":", 54};
            54: r = '{OP_DIG, F_SEC, 55};  55: r = '{OP_DIG, F_SEC, 56};
            56: r = '{OP_LIT, " ", 57};
            57: r = '{OP_DIG, F_YEAR, 58}; 58: r = '{OP_DIG, F_YEAR, 59};
            59: r = '{OP_DIG, F_YEAR, 60}; 60: r = '{OP_DIG, F_YEAR, 61};
            61: r = '{OP_END, 0, 61};
            default: r = '{OP_BAD, 0, 0};
        endcase
        return r;
    endfunction

    function automatic logic [7:0] lower(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic bit is_dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    task automatic clear_parse();
        ph = PH_WS; nlen = 0; dcand = 7'h7F; mcand = 0;
        dv = 0; mv = 0; yv = 0; hv = 0; miv = 0; sv = 0; ffmt = FMT_NONE; fail = 0;
    endtask

    task automatic add_digit(logic [7:0] fld, int d);
        case (fld)
            F_DAY:  dv = dv * 10 + d;
            F_HOUR: hv = hv * 10 + d;
            F_MIN:  miv = miv * 10 + d;
            F_SEC:  sv = sv * 10 + d;
            default: yv = yv * 10 + d;
        endcase
    endtask

    task automatic day_name_char(logic [7:0] c);
        logic [6:0] keep;
        keep = 0;
        if (nlen == 3 && c == CH_COMMA && dcand != 0) begin
            ffmt = FMT_IMF; ph = PH_IMF;
        end else if (nlen == 3 && c == CH_SP && dcand != 0) begin
            ffmt = FMT_ASC; ph = PH_ASC;
        end else if (c == CH_COMMA && nlen >= 6 && nlen <= 9) begin
            for (int k = 0; k < 7; k++)
                if (dcand[k] && day_names[k].len() == nlen) keep = 1;
            if (keep != 0) begin
                ffmt = FMT_RFC; ph = PH_RFC;
            end else begin
                fail = 1;
            end
        end else if (nlen >= 9) begin
            fail = 1;
        end else begin
            for (int k = 0; k < 7; k++)
                if (dcand[k] && nlen < day_names[k].len() && lower(c) == day_names[k][nlen])
                    keep[k] = 1;
            if (keep == 0) fail = 1;
            else begin
                dcand = keep; nlen = nlen + 1;
            end
        end
    endtask

    task automatic parse_char(logic [7:0] c);
        rule_t      r;
        logic [11:0] keep;
        keep = 0;
        if (fail) return;
        if (ph >= PH_COUNT) begin
            fail = 1; return;
        end
        r = rule(ph);
        case (r.op)
            OP_WS: begin
                if (c != CH_SP && c != CH_TAB) begin
                    ph = PH_NAME; nlen = 0; dcand = 7'h7F;
                    day_name_char(c);
                end
            end
            OP_NAME: day_name_char(c);
            OP_LIT: if (c == r.arg) ph = r.nx; else fail = 1;
            OP_DIG: begin
                if (is_dig(c)) begin
                    add_digit(r.arg, c - CH_ZERO); ph = r.nx;
                end else fail = 1;
            end
            OP_MON: begin
                if (r.arg == 0) mcand = 12'hFFF;
                for (int m = 0; m < 12; m++)
                    if (mcand[m] && lower(c) == mon_names[m * 3 + r.arg]) keep[m] = 1;
                mcand = keep;
                if (keep == 0) fail = 1;
                else begin
                    if (r.arg == 2)
                        for (int m = 11; m >= 0; m--) if (keep[m]) mv = m;
                    ph = r.nx;
                end
            end
            OP_PAD: begin
                if (c == CH_SP || c == CH_TAB) ph = r.arg[5:0];
                else if (is_dig(c)) begin
                    dv = c - CH_ZERO; ph = r.nx;
                end else fail = 1;
            end
            OP_DAY2: begin
                if (is_dig(c)) begin
                    add_digit(F_DAY, c - CH_ZERO); ph = r.nx;
                end else if (c == CH_SP && r.arg != 0) ph = r.arg[5:0];
                else fail = 1;
            end
            default: fail = 1;
        endcase
    endtask

    function automatic epoch_res_t finish_date();
        epoch_res_t res;
        int     yr, dmax;
        longint y, era, yoe, mp, doy, doe, dnum, mo;
        res = '0;
        if (fail || ph >= PH_COUNT || rule(ph).op != OP_END) return res;
        yr = yv;
        if (ffmt == FMT_RFC) yr = (yv >= pivot) ? 1900 + yv : 2000 + yv;
        if (mv > 11 || yr < 1 || yr > 9999) return res;
        dmax = mon_len[mv];
        if (mv == 1 && ((yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0)) dmax++;
        if (dv < 1 || dv > dmax) return res;
        if (hv > 23 || miv > 59 || sv > 60) return res;
        mo = mv + 1;
        y = yr - (mo <= 2 ? 1 : 0);
        era = y / 400;
        yoe = y - era * 400;
        mp = (mo > 2) ? mo - 3 : mo + 9;
        doy = (153 * mp + 2) / 5 + dv - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        dnum = era * 146097 + doe - 719468;
        res.ok = 1;
        res.fmt = ffmt;
        res.secs = dnum * 86400 + hv * 3600 + miv * 60 + sv;
        return res;
    endfunction

    task automatic predict_byte(logic [7:0] c, logic l);
        parse_char(c);
        if (l) begin
            epoch_q.push_back(finish_date());
            clear_parse();
        end
    endtask

    initial clear_parse();

    // request driver
    int    in_gap = 0;
    char_t nxt;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_byte(s_tdata, s_tlast);
                bytes_sent++;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (in_gap > 0) begin
                    in_gap--;
                    s_tvalid <= 1'b0;
                end else if (feed_q.size() > 0 && !quiet && $urandom_range(0, 11) == 0) begin
                    in_gap = $urandom_range(0, 15);
                    s_tvalid <= 1'b0;
                end else if (feed_q.size() > 0) begin
                    nxt = feed_q.pop_front();
                    s_tdata <= nxt.b;
                    s_tlast <= nxt.l;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    int         out_gap = 0;
    epoch_res_t want;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                strings_done++;
                if (epoch_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result tuser=%h tdata=%h", m_tuser, m_tdata);
                end else begin
                    want = epoch_q.pop_front();
                    if (m_tuser[0] !== want.ok || m_tuser[2:1] !== want.fmt
                        || m_tdata[38:0] !== want.secs) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch: exp ok=%0d fmt=%0d secs=%0d",
                                     want.ok, want.fmt, want.secs);
                            $display("          got ok=%0d fmt=%0d secs=%0d",
                                     m_tuser[0], m_tuser[2:1], $signed(m_tdata[38:0]));
                        end
                    end else if (want.ok) begin
                        ok_seen++;
                        fmt_seen[want.fmt]++;
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                out_gap = $urandom_range(0, 15);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no handshake at all
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= 4000) begin
            $display("watchdog expired, %0d results outstanding", epoch_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // stimulus helpers
    task automatic push_bytes(logic [7:0] bs[$]);
        for (int i = 0; i < bs.size(); i++) feed_q.push_back('{bs[i], i == bs.size() - 1});
    endtask

    task automatic push_str(string s);
        logic [7:0] bs[$];
        for (int i = 0; i < s.len(); i++) bs.push_back(s[i]);
        push_bytes(bs);
    endtask

    task automatic wait_drained();
        while (feed_q.size() > 0 || s_tvalid || epoch_q.size() > 0) @(posedge aclk);
        // every accepted string has been checked by now; idle before returning
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_pivot(logic [6:0] v);
        wait_drained();
        @(posedge aclk);
        cfg_wen <= 1'b1;
        cfg_wdata <= v;
        pivot = v;
        @(posedge aclk);
        cfg_wen <= 1'b0;
    endtask

    function automatic string mix_case(string s);
        for (int i = 0; i < s.len(); i++)
            if ($urandom_range(0, 3) == 0 && lower(s[i]) >= "a" && lower(s[i]) <= "z")
                s[i] = s[i] ^ 8'h20;
        return s;
    endfunction

    function automatic string rand_date();
        string s, dn, mn, pre;
        int    d, mo, yr, h, mi, se, k;
        k = $urandom_range(0, 6);
        mo = $urandom_range(0, 11);
        d = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 28);
        yr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9999) : $urandom_range(1900, 2100);
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 29) : $urandom_range(0, 23);
        mi = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 69) : $urandom_range(0, 59);
        se = ($urandom_range(0, 9) == 0) ? $urandom_range(55, 61) : $urandom_range(0, 59);
        mn = mix_case(mon_names.substr(mo * 3, mo * 3 + 2));
        pre = "";
        if ($urandom_range(0, 4) == 0) pre = ($urandom_range(0, 1) != 0) ? " " : "\t \t";
        case ($urandom_range(0, 2))
            0: begin
                dn = mix_case(day_names[k].substr(0, 2));
                s = $sformatf("%s%s, %02d %s %04d %02d:%02d:%02d GMT",
                              pre, dn, d, mn, yr, h, mi, se);
            end
            1: begin
                dn = mix_case(day_names[k]);
                s = $sformatf("%s%s, %02d-%s-%02d %02d:%02d:%02d GMT", pre, dn, d, mn, yr % 100,
                              h, mi, se);
            end
            default: begin
                dn = mix_case(day_names[k].substr(0, 2));
                s = $sformatf("%s%s %s %s %02d:%02d:%02d %04d", pre, dn, mn,
                              (d < 10) ? (($urandom_range(0, 1) != 0) ? $sformatf(" %0d", d)
                                                                       : $sformatf("%02d", d))
                                       : $sformatf("%0d", d), h, mi, se, yr);
            end
        endcase
        return s;
    endfunction

    task automatic push_random_string();
        string      s;
        logic [7:0] bs[$];
        int         sel;
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
            // pure noise
            repeat ($urandom_range(1, 35)) bs.push_back($urandom_range(0, 255));
        end else begin
            s = rand_date();
            for (int i = 0; i < s.len(); i++) bs.push_back(s[i]);
            if (sel < 22) bs[$urandom_range(0, bs.size() - 1)] = $urandom_range(0, 255);
            else if (sel < 27) void'(bs.pop_back());
            else if (sel < 31) bs.push_back($urandom_range(0, 255));
        end
        push_bytes(bs);
    endtask

    logic [6:0] pivots[5] = '{7'd0, 7'd99, 7'd127, 7'd0, 7'd69};

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed strings under the reset pivot
        push_str("Sun, 06 Nov 1994 08:49:37 GMT");
        push_str("Sunday, 06-Nov-94 08:49:37 GMT");
        push_str("Sun Nov  6 08:49:37 1994");
        push_str("Wed Dec 31 23:59:59 1969");
        push_str("tHU, 01 jAN 1970 00:00:00 GMT");
        push_str("Sat, 31 Dec 2016 23:59:60 GMT");
        push_str("Mon, 01 Jan 0001 00:00:00 GMT");
        push_str("Fri, 31 Dec 9999 23:59:59 GMT");
        push_str("Fri, 31 Dec 0000 23:59:59 GMT");
        push_str("Tue, 29 Feb 2000 12:00:00 GMT");
        push_str("Wed, 29 Feb 1900 12:00:00 GMT");
        push_str("WEDNESDAY, 31-Dec-68 10:00:00 GMT");
        push_str("Thursday, 01-Jan-69 10:00:00 GMT");
        push_str(" \t Sat Jan 05 01:02:03 2008");
        push_str("Sat Jan 5 01:02:03 2008");
        push_str("Sun, 06 Nov 1994 08:49:37 gmt");
        push_str("Sun, 06 Nov 1994 08:49:37 GMTX");
        push_str("Sun, 06 Nov 1994 24:00:00 GMT");
        push_str("Sun, 31 Apr 1994 08:61:37 GMT");
        push_str("  \t ");
        push_str("Funday, 01-Jan-00 00:00:00 GMT");
        push_bytes('{8'hFF, 8'h00, 8'h80});

        // random strings across pivot settings, extremes included
        for (int p = 0; p < 6; p++) begin
            if (p > 0) set_pivot(p == 5 ? $urandom_range(0, 127) : pivots[p - 1]);
            while (bytes_sent + feed_q.size() < (p + 1) * 240 && feed_q.size() < 4000) begin
                push_random_string();
                while (feed_q.size() > 60) @(posedge aclk);
            end
            if (p == 5) begin
                quiet = 1;
                repeat (8) push_random_string();
            end
        end
        wait_drained();

        $display("%0d strings checked, %0d bytes sent, %0d valid",
                 strings_done, bytes_sent, ok_seen);
        $display("valid by format: imf %0d, rfc850 %0d, asctime %0d",
                 fmt_seen[1], fmt_seen[2], fmt_seen[3]);
        $display("pivots exercised: 69, 0, 99, 127 and one random value");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches", errors);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/hdse_pkg.sv
rtl/core/hdse_front.sv
rtl/core/hdse_queue.sv
rtl/core/hdse_back.sv
rtl/core/http_date_string_to_epoch.sv
rtl/core/hdse_chk.sv
tb/http_date_string_to_epoch_tb.sv
